FILE: src/hgcd_pkg.sv
`timescale 1ns / 1ps
// Package for the haversine distance pipeline: formats, CORDIC tables and
// rounding tables. No dependencies.
package hgcd_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int SQRT_STEPS   = 31;

   // Sphere radius after reset, whole km
   localparam logic [15:0] RADIUS_RESET = 16'd6371;

   // Degree to phase: |v| * 2^(29-F) / 45, rounded half up
   localparam int          PH_SHIFT = 29 - FRAC_BITS;
   localparam logic [24:0] RECIP45  = 25'd23860930;   // ceil(2^30 / 45)

   // CORDIC constants (Q30, one turn = 2^32)
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [31:0] FOUR_PI_Q28 = 32'd3373259426;

   // Final scaling
   localparam int          D_SHIFT = 30 - FRAC_BITS;
   localparam logic [48:0] D_ROUND = 49'd1 << (29 - FRAC_BITS);

   typedef logic [31:0]        phase_type;
   typedef logic signed [31:0] cos_type;
   typedef logic signed [33:0] cord_type;
   typedef logic [30:0]        q30_type;
   typedef logic [31:0]        rnd_tbl_type [45];

   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   // Rounded fraction of a turn for remainders 0..44 of |v| / 45
   function automatic rnd_tbl_type build_rnd_tbl();
      rnd_tbl_type t;
      for (int i = 0; i < 45; i++) begin
         t[i] = 32'(((longint'(i) << (30 - FRAC_BITS)) + 45) / 90);
      end
      return t;
   endfunction

   localparam rnd_tbl_type RND_TBL = build_rnd_tbl();

endpackage

FILE: src/hgcd_if.sv
`timescale 1ns / 1ps
// Valid/ready channels for point pairs and distances.
// Depends on nothing but the field widths.
interface hgcd_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] lat_a;
   logic signed [24:0] lon_a;
   logic signed [23:0] lat_b;
   logic signed [24:0] lon_b;

   modport source(output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink(input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hgcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [33:0] distance;

   modport source(output valid, distance, input ready);
   modport sink(input valid, distance, output ready);
endinterface

FILE: src/hgcd_phase.sv
`timescale 1ns / 1ps
// Degrees (signed, FRAC_BITS fraction bits) to a 32-bit turn phase, two stages.
// Depends on hgcd_pkg.
module hgcd_phase (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic signed [24:0] in_angle,
   output logic               out_valid,
   output hgcd_pkg::phase_type out_phase
);
   import hgcd_pkg::*;

   logic [24:0] mag_in, mag_ff;
   logic [49:0] prod_in, prod_ff;
   logic        neg_ff;
   logic        vld_ff;
   logic [19:0] quo;
   logic [24:0] rem_full;
   logic [5:0]  rem;
   phase_type   mag_ph;
   phase_type   phase_in, phase_ff;
   logic        out_vld_ff;

   // Stage 1: magnitude and reciprocal multiply for |v| / 45
   always_comb begin
      mag_in  = in_angle[24] ? 25'(-in_angle) : 25'(in_angle);
      prod_in = 50'(mag_in) * 50'(RECIP45);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         neg_ff  <= in_angle[24];
      end
   end

   // Stage 2: quotient, remainder, rounded table fraction, sign
   always_comb begin
      quo      = prod_ff[49:30];
      rem_full = mag_ff - 25'(quo) * 25'd45;
      rem      = rem_full[5:0];
      mag_ph   = 32'(52'(quo) << PH_SHIFT) + RND_TBL[rem];
      phase_in = neg_ff ? 32'(-mag_ph) : mag_ph;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= in_valid;
         out_vld_ff <= vld_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_phase = phase_ff;
endmodule

FILE: src/hgcd_cos_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC cosine: fold, one rotation step per stage, clamp and sign.
// Depends on hgcd_pkg.
module hgcd_cos_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  hgcd_pkg::phase_type in_phase,
   output logic                out_valid,
   output hgcd_pkg::cos_type   out_cos
);
   import hgcd_pkg::*;

   cord_type  x_ff [CORDIC_STEPS+1];
   cord_type  y_ff [CORDIC_STEPS+1];
   cord_type  z_ff [CORDIC_STEPS+1];
   logic      neg_ff [CORDIC_STEPS+1];
   logic      vld_ff [CORDIC_STEPS+1];
   logic      fold;
   phase_type folded;
   cord_type  xc;
   cos_type   cos_in, cos_ff;
   logic      out_vld_ff;

   // Fold into [-90, 90) degrees
   always_comb begin
      fold   = phase_type'(in_phase + 32'h4000_0000) >> 31 != 32'd0;
      folded = fold ? phase_type'(in_phase + 32'h8000_0000) : in_phase;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= cord_type'(signed'(folded));
         neg_ff[0] <= fold;
      end
   end

   // Rotation steps
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cord_type dx, dy, x_in, y_in, z_in, a;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         a  = cord_type'(ATAN_TURNS[i]);
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - a;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + a;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   // Clamp to [-1, 1] and undo the fold
   always_comb begin
      xc = x_ff[CORDIC_STEPS];
      if (xc > ONE_Q30) xc = ONE_Q30;
      if (xc < -ONE_Q30) xc = -ONE_Q30;
      cos_in = neg_ff[CORDIC_STEPS] ? 32'(-xc) : 32'(xc);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) vld_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= CORDIC_STEPS; k++) vld_ff[k] <= vld_ff[k-1];
         out_vld_ff <= vld_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_cos   = cos_ff;
endmodule

FILE: src/hgcd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of a Q30 value shifted left by 30, one result
// bit per stage. Depends on hgcd_pkg.
module hgcd_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  hgcd_pkg::q30_type in_val,
   output logic              out_valid,
   output hgcd_pkg::q30_type out_root
);
   import hgcd_pkg::*;

   logic [60:0] v_ff [SQRT_STEPS];
   logic [61:0] r_ff [SQRT_STEPS];
   logic        vld_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
      logic [60:0] v_src, v_in;
      logic [61:0] r_src, r_in, trial;
      if (k == 0) begin : g_first
         assign v_src = {in_val, 30'd0};
         assign r_src = '0;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign r_src = r_ff[k-1];
      end
      always_comb begin
         trial = r_src + BIT;
         if (62'(v_src) >= trial) begin
            v_in = v_src - 61'(trial);
            r_in = (r_src >> 1) + BIT;
         end else begin
            v_in = v_src;
            r_in = r_src >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            v_ff[k] <= v_in;
            r_ff[k] <= r_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < SQRT_STEPS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = r_ff[SQRT_STEPS-1][30:0];
endmodule

FILE: src/hgcd_atan_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring: angle of (c, s) as a phase, clamped to a
// quarter turn. Depends on hgcd_pkg.
module hgcd_atan_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  hgcd_pkg::q30_type in_s,
   input  hgcd_pkg::q30_type in_c,
   output logic              out_valid,
   output hgcd_pkg::q30_type out_angle
);
   import hgcd_pkg::*;

   cord_type x_ff [CORDIC_STEPS];
   cord_type y_ff [CORDIC_STEPS];
   cord_type z_ff [CORDIC_STEPS];
   logic     vld_ff [CORDIC_STEPS];
   cord_type zc;
   q30_type  ang_in, ang_ff;
   logic     out_vld_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cord_type xs, ys, zs, dx, dy, a, x_in, y_in, z_in;
      if (i == 0) begin : g_first
         assign xs = cord_type'(in_c);
         assign ys = cord_type'(in_s);
         assign zs = '0;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end
      always_comb begin
         dx = ys >>> i;
         dy = xs >>> i;
         a  = cord_type'(ATAN_TURNS[i]);
         if (ys > 0) begin
            x_in = xs + dx;
            y_in = ys - dy;
            z_in = zs + a;
         end else begin
            x_in = xs - dx;
            y_in = ys + dy;
            z_in = zs - a;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   // Clamp to [0, quarter turn]
   always_comb begin
      zc = z_ff[CORDIC_STEPS-1];
      if (zc < 0) zc = '0;
      if (zc > ONE_Q30) zc = ONE_Q30;
      ang_in = zc[30:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ang_ff <= ang_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) vld_ff[k] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < CORDIC_STEPS; k++) vld_ff[k] <= vld_ff[k-1];
         out_vld_ff <= vld_ff[CORDIC_STEPS-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_angle = ang_ff;
endmodule

FILE: src/haversine_great_circle_distance.sv
`timescale 1ns / 1ps
// Haversine great-circle distance, fully pipelined: one point pair per cycle
// sustained while responses are taken. The depth is set by the CORDIC (20
// steps each) and square-root (31 bits) stages.
// The whole pipeline stalls while a finished response is not taken.
// Synchronous reset clears all valid bits and sets the radius register to 6371.
// Depends on hgcd_pkg, hgcd_if and the hgcd_* submodules.
module haversine_great_circle_distance (
   input  logic              clock,
   input  logic              reset,
   hgcd_req_if.sink          req_chan,
   hgcd_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import hgcd_pkg::*;

   logic        advance;
   logic [15:0] radius_ff;

   // Phases
   logic      ph_vld;
   phase_type pla, plo_a, plb, plo_b;
   logic      ph_vld_b, ph_vld_c, ph_vld_d;

   // Cosines
   logic    c_vld, c_vld_b, c_vld_c, c_vld_d;
   cos_type ca, cb, cd, cl;

   // Haversine sum stages
   logic signed [63:0] ccp_in, ccp_ff, p2_in, p2_ff;
   logic signed [32:0] dlat_diff, dlon_diff;
   q30_type            hd_ff, hl_ff, hd2_ff;
   logic signed [31:0] cc;
   logic signed [33:0] h_s;
   q30_type            h_in, h_ff, hc;
   logic               h1_vld_ff, h2_vld_ff, h3_vld_ff;

   // Root, angle, scale
   logic    s_vld, c2_vld, a_vld;
   q30_type s_root, c_root, ang;
   logic [63:0] tprod_in, tprod_ff, tsum;
   logic [31:0] t_ff;
   logic [47:0] dprod_ff;
   logic [48:0] dsum, dsh;
   logic [33:0] d_in, d_ff;
   logic        t1_vld_ff, t2_vld_ff, t3_vld_ff, out_vld_ff;

   // Pipeline moves unless a finished response is held
   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   // Degree to phase
   hgcd_phase u_ph_lat_a (.clock, .reset, .advance, .in_valid(req_chan.valid),
      .in_angle(25'(req_chan.lat_a)), .out_valid(ph_vld), .out_phase(pla));
   hgcd_phase u_ph_lon_a (.clock, .reset, .advance, .in_valid(req_chan.valid),
      .in_angle(req_chan.lon_a), .out_valid(ph_vld_b), .out_phase(plo_a));
   hgcd_phase u_ph_lat_b (.clock, .reset, .advance, .in_valid(req_chan.valid),
      .in_angle(25'(req_chan.lat_b)), .out_valid(ph_vld_c), .out_phase(plb));
   hgcd_phase u_ph_lon_b (.clock, .reset, .advance, .in_valid(req_chan.valid),
      .in_angle(req_chan.lon_b), .out_valid(ph_vld_d), .out_phase(plo_b));

   // Four cosines
   hgcd_cos_cordic u_cos_a (.clock, .reset, .advance, .in_valid(ph_vld),
      .in_phase(pla), .out_valid(c_vld), .out_cos(ca));
   hgcd_cos_cordic u_cos_b (.clock, .reset, .advance, .in_valid(ph_vld_b),
      .in_phase(plb), .out_valid(c_vld_b), .out_cos(cb));
   hgcd_cos_cordic u_cos_dlat (.clock, .reset, .advance, .in_valid(ph_vld_c),
      .in_phase(phase_type'(plb - pla)), .out_valid(c_vld_c), .out_cos(cd));
   hgcd_cos_cordic u_cos_dlon (.clock, .reset, .advance, .in_valid(ph_vld_d),
      .in_phase(phase_type'(plo_b - plo_a)), .out_valid(c_vld_d), .out_cos(cl));

   // Sum stage 1: cos a * cos b, half versines
   always_comb begin
      ccp_in    = 64'(ca) * 64'(cb);
      dlat_diff = 33'(ONE_Q30) - 33'(cd);
      dlon_diff = 33'(ONE_Q30) - 33'(cl);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ccp_ff <= ccp_in;
         hd_ff  <= dlat_diff[31:1];
         hl_ff  <= dlon_diff[31:1];
      end
   end

   // Sum stage 2: times the longitude term
   always_comb begin
      cc    = 32'(ccp_ff >>> 30);
      p2_in = 64'(cc) * signed'(64'(hl_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_ff  <= p2_in;
         hd2_ff <= hd_ff;
      end
   end

   // Sum stage 3: add and clamp to [0, 1]
   always_comb begin
      h_s = signed'(34'(hd2_ff)) + 34'(p2_ff >>> 30);
      if (h_s < 0) begin
         h_in = '0;
      end else if (h_s > ONE_Q30) begin
         h_in = ONE_Q30[30:0];
      end else begin
         h_in = h_s[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h_ff <= h_in;
      end
   end

   assign hc = ONE_Q30[30:0] - h_ff;

   // Square roots of h and 1 - h
   hgcd_isqrt u_sqrt_s (.clock, .reset, .advance, .in_valid(h3_vld_ff),
      .in_val(h_ff), .out_valid(s_vld), .out_root(s_root));
   hgcd_isqrt u_sqrt_c (.clock, .reset, .advance, .in_valid(h3_vld_ff),
      .in_val(hc), .out_valid(c2_vld), .out_root(c_root));

   hgcd_atan_cordic u_atan (.clock, .reset, .advance, .in_valid(s_vld && c2_vld),
      .in_s(s_root), .in_c(c_root), .out_valid(a_vld), .out_angle(ang));

   // Scale: angle times 4 pi, then times radius, with rounding and saturation
   assign tprod_in = 64'(ang) * 64'(FOUR_PI_Q28);
   assign tsum     = tprod_ff + 64'(1 << 29);

   always_comb begin
      dsum = 49'(dprod_ff) + D_ROUND;
      dsh  = dsum >> D_SHIFT;
      d_in = (|dsh[48:34]) ? '1 : dsh[33:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tprod_ff <= tprod_in;
         t_ff     <= tsum[61:30];
         dprod_ff <= 48'(radius_ff) * 48'(t_ff);
         d_ff     <= d_in;
      end
   end

   // Valid bits of the local stages
   always_ff @(posedge clock) begin
      if (reset) begin
         h1_vld_ff  <= 1'b0;
         h2_vld_ff  <= 1'b0;
         h3_vld_ff  <= 1'b0;
         t1_vld_ff  <= 1'b0;
         t2_vld_ff  <= 1'b0;
         t3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         h1_vld_ff  <= c_vld && c_vld_b && c_vld_c && c_vld_d;
         h2_vld_ff  <= h1_vld_ff;
         h3_vld_ff  <= h2_vld_ff;
         t1_vld_ff  <= a_vld;
         t2_vld_ff  <= t1_vld_ff;
         t3_vld_ff  <= t2_vld_ff;
         out_vld_ff <= t3_vld_ff;
      end
   end

   assign rsp_chan.valid    = out_vld_ff;
   assign rsp_chan.distance = d_ff;
endmodule

FILE: dv/hgcd_checker.sv
`timescale 1ns / 1ps
// Distance checker: watches request and response transfers, predicts each
// distance with a local haversine model and compares. Depends on hgcd_if.
module hgcd_checker (
   input  logic       clock,
   input  logic       reset,
   hgcd_req_if.sink   req_mon,
   hgcd_rsp_if.sink   rsp_mon,
   input  logic       csr_we,
   input  logic [15:0] csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         seen
);

   localparam longint ONE = 64'sd1 << 30;
   localparam int     STEPS = 20;
   localparam int     FB = 16;

   longint atan_tbl [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   logic [15:0] radius;
   logic [33:0] dist_q[$];

   function automatic logic [31:0] to_phase(longint v);
      logic [63:0] mag, den, p;
      mag = (v < 0) ? -v : v;
      den = 64'd360 << FB;
      p = ((mag << 32) + (den >> 1)) / den;
      return (v < 0) ? 32'(-p) : p[31:0];
   endfunction

   function automatic longint cos_val(logic [31:0] ph);
      logic   neg;
      logic [31:0] t;
      longint x, y, z, dx, dy;
      neg = 0;
      x = 652032874;
      y = 0;
      t = ph + 32'h4000_0000;
      if (t[31]) begin
         ph = ph + 32'h8000_0000;
         neg = 1;
      end
      z = longint'($signed(ph));
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tbl[i];
         end else begin
            x += dx; y -= dy; z += atan_tbl[i];
         end
      end
      if (x > ONE) x = ONE;
      if (x < -ONE) x = -ONE;
      return neg ? -x : x;
   endfunction

   function automatic longint int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic logic [33:0] great_circle(longint la, longint oa, longint lb,
                                                longint ob, logic [15:0] rad);
      logic [31:0] pa, qa, pb, qb;
      longint ca, cb, cd, cl, cc, h, x, y, z, dx, dy;
      logic [63:0] t, d;
      pa = to_phase(la); qa = to_phase(oa);
      pb = to_phase(lb); qb = to_phase(ob);
      ca = cos_val(pa); cb = cos_val(pb);
      cd = cos_val(pb - pa); cl = cos_val(qb - qa);
      cc = (ca * cb) >>> 30;
      h = ((ONE - cd) >>> 1) + ((cc * ((ONE - cl) >>> 1)) >>> 30);
      if (h < 0) h = 0;
      if (h > ONE) h = ONE;
      y = int_sqrt(64'(h) << 30);
      x = int_sqrt(64'(ONE - h) << 30);
      z = 0;
      // vectoring CORDIC for atan2(s, c)
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += atan_tbl[i];
         end else begin
            x -= dx; y += dy; z -= atan_tbl[i];
         end
      end
      if (z < 0) z = 0;
      if (z > ONE) z = ONE;
      t = (64'(z) * 64'd3373259426 + (64'd1 << 29)) >> 30;
      d = (64'(rad) * t + (64'd1 << (29 - FB))) >> (30 - FB);
      if (d > 64'h3_FFFF_FFFF) d = 64'h3_FFFF_FFFF;
      return d[33:0];
   endfunction

   assign pending = dist_q.size();

   always @(posedge clock) begin
      logic [33:0] exp_d;
      if (reset) begin
         radius <= 16'd6371;
         dist_q.delete();
         fail_count <= 0;
         seen <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            dist_q.push_back(great_circle(req_mon.lat_a, req_mon.lon_a,
                                          req_mon.lat_b, req_mon.lon_b, radius));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen <= seen + 1;
            if (dist_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected distance %0d", rsp_mon.distance);
               fail_count <= fail_count + 1;
            end else begin
               exp_d = dist_q.pop_front();
               if (exp_d !== rsp_mon.distance) begin
                  if (fail_count < 10)
                     $display("distance mismatch: expected %0d got %0d", exp_d,
                              rsp_mon.distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) radius <= csr_wdata;
      end
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the distance testbench: clock, reset, point-pair stimulus, response
// stalls and verdict. Depends on hgcd_pkg, hgcd_if, hgcd_checker and the RTL.
module tb_top;
   import hgcd_pkg::*;

   localparam int LATENCY = 83;
   localparam int LIMIT = 400000;
   localparam int LAT_MAX = 5898240;
   localparam int LON_MAX = 11796480;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [15:0] csr_wdata = '0;
   int   fails, pending, seen, cycles = 0;
   logic long_hold = 0;

   hgcd_req_if req_chan ();
   hgcd_rsp_if rsp_chan ();

   haversine_great_circle_distance DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source), .csr_we(csr_we), .csr_wdata(csr_wdata));

   hgcd_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_chan.sink), .rsp_mon(rsp_chan.sink),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .fail_count(fails),
      .pending(pending), .seen(seen));

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.lat_a = '0; req_chan.lon_a = '0;
      req_chan.lat_b = '0; req_chan.lon_b = '0;
      rsp_chan.ready = 0;
   end

   // timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      int mode;
      mode = (cycles / 500) % 3;
      if (long_hold) rsp_chan.ready <= 0;
      else if (mode == 0) rsp_chan.ready <= 1;
      else if (mode == 1) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      else rsp_chan.ready <= ($urandom_range(0, 1) == 0);
   end

   // one pair offered until transfer; valid kept high across back-to-back items,
   // otherwise dropped before the next item
   task automatic send_pair(int la, int oa, int lb, int ob, bit keep);
      req_chan.valid <= 1;
      req_chan.lat_a <= la[23:0]; req_chan.lon_a <= oa[24:0];
      req_chan.lat_b <= lb[23:0]; req_chan.lon_b <= ob[24:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      if (!keep) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic set_radius(logic [15:0] r);
      drain();
      csr_wdata <= r;
      csr_we <= 1;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic int rand_angle(int lim);
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return $urandom;                 // arbitrary wrapped pattern
      if (k == 1) return ($urandom_range(0, 1) ? lim : -lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   task automatic random_burst(int n);
      int left, len, la;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, 20);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            la = rand_angle(LAT_MAX);
            // nearby pairs now and then for small distances
            if ($urandom_range(0, 4) == 0)
               send_pair(la, rand_angle(LON_MAX), la + $urandom_range(0, 2000) - 1000,
                         rand_angle(LON_MAX), i != len - 1);
            else
               send_pair(la, rand_angle(LON_MAX), rand_angle(LAT_MAX),
                         rand_angle(LON_MAX), i != len - 1);
         end
         left -= len;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   initial begin
      logic [15:0] radii [4] = '{16'd1, 16'd65535, 16'd0, 16'd40000};
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: poles, antipodes, equal points, field extremes, wrap patterns
      send_pair(0, 0, 0, 0, 0);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
      send_pair(0, 0, 0, LON_MAX, 0);
      send_pair(0, -LON_MAX, 0, LON_MAX, 1);
      send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 1);
      send_pair(1, 1, 0, 0, 1);
      send_pair(-1, -1, 1, 1, 0);
      send_pair(32'h7FFFFF, 32'hFFFFFF, 32'h800000, 32'h1000000, 0);
      send_pair(-32'h800000, -32'h1000000, 32'h7FFFFF, 32'hFFFFFF, 0);
      send_pair(3276800, 0, -3276800, 5898240, 0);
      send_pair(LAT_MAX, 123456, LAT_MAX, -654321, 0);
      send_pair(2949120, 2949120, 2949121, 2949120, 0);
      random_burst(150);
      // receiver holds off while sender keeps offering
      long_hold = 1;
      fork
         random_burst(150);
         begin repeat (300) @(negedge clock); long_hold = 0; end
      join
      for (int r = 0; r < 4; r++) begin
         set_radius(radii[r]);
         send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
         random_burst(r == 3 ? 250 : 100);
      end
      set_radius(16'd6371);
      random_burst(50);
      drain();
      $display("covered %0d distances over radii 1, 65535, 0, 40000 and 6371", seen);
      if (fails == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule
